>>> design/qodo_pkg.sv
// qodo_pkg: shared types and widths for the quadrature odometry core.
// No dependencies; imported by the register file, multiplier and top level.

package qodo_pkg;

	// Width of a configuration word and of one multiplier operand
	localparam int unsigned WORD_W = 32;

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic              left_reverse;
		logic              right_reverse;
		logic [WORD_W-1:0] left_gain;
		logic [WORD_W-1:0] right_gain;
		logic [WORD_W-1:0] deg_gain;
	} cfg_t;

endpackage

>>> design/qodo_apb.sv
// qodo_apb: APB register file holding polarity bits and Q8.24 gains.
// Depends on qodo_pkg (cfg_t, WORD_W).

module qodo_apb import qodo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	typedef enum logic [2:0] {
		REG_LEFT_REV  = 3'd0,
		REG_RIGHT_REV = 3'd1,
		REG_LEFT_MM   = 3'd2,
		REG_RIGHT_MM  = 3'd3,
		REG_DEG_MM    = 3'd4
	} reg_idx_t;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_LEFT_REV:  cfg_q.left_reverse  <= pwdata[0];
				REG_RIGHT_REV: cfg_q.right_reverse <= pwdata[0];
				REG_LEFT_MM:   cfg_q.left_gain     <= pwdata;
				REG_RIGHT_MM:  cfg_q.right_gain    <= pwdata;
				REG_DEG_MM:    cfg_q.deg_gain      <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_LEFT_REV:  prdata = WORD_W'(cfg_q.left_reverse);
			REG_RIGHT_REV: prdata = WORD_W'(cfg_q.right_reverse);
			REG_LEFT_MM:   prdata = cfg_q.left_gain;
			REG_RIGHT_MM:  prdata = cfg_q.right_gain;
			REG_DEG_MM:    prdata = cfg_q.deg_gain;
			default:       prdata = '0;
		endcase
	end

endmodule

>>> design/qodo_mul.sv
// qodo_mul: shared 32x32 unsigned multiplier with a registered product.
// Depends on qodo_pkg (WORD_W).

module qodo_mul import qodo_pkg::*; (
	input  logic                clk,
	input  logic [WORD_W-1:0]   op_a,
	input  logic [WORD_W-1:0]   op_b,
	output logic [2*WORD_W-1:0] prod_q
);

	// Product is registered: it is available in the cycle after the operands are presented
	always_ff @(posedge clk) begin
		prod_q <= (2*WORD_W)'(op_a) * (2*WORD_W)'(op_b);
	end

endmodule

>>> design/qodo_edge.sv
// qodo_edge: quadrature edge decoder and saturating count for one wheel.
// No package dependency; instantiated twice by the top level.

module qodo_edge #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 clear,
	input  logic                 pin_clk,
	input  logic                 pin_b,
	input  logic                 reverse,
	output logic signed [CW-1:0] count
);

	localparam logic signed [CW:0] Lim  = (CW+1)'((64'd1 << (CW-1)) - 64'd1);
	localparam logic signed [CW:0] LimN = -Lim;
	localparam logic signed [CW:0] One  = (CW+1)'(1);

	logic                 a_q, b_q;
	logic signed [CW-1:0] cnt_q;
	logic                 new_a, up_raw, dn_raw, up, dn;
	logic signed [CW:0]   delta, sum;
	logic signed [CW-1:0] cnt_next;

	assign count = cnt_q;

	// Decode the transition and clamp the count
	always_comb begin
		new_a  = pin_clk ^ pin_b;
		up_raw = a_q ^ pin_b;
		dn_raw = new_a ^ b_q;
		up     = reverse ? dn_raw : up_raw;
		dn     = reverse ? up_raw : dn_raw;
		if (up && !dn) begin
			delta = One;
		end else if (dn && !up) begin
			delta = -One;
		end else begin
			delta = '0;
		end
		sum = (CW+1)'(cnt_q) + delta;
		if (sum > Lim) begin
			cnt_next = CW'(Lim);
		end else if (sum < LimN) begin
			cnt_next = CW'(LimN);
		end else begin
			cnt_next = CW'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= 1'b0;
			b_q   <= 1'b0;
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_next;
			a_q   <= new_a;
			b_q   <= pin_b;
		end
	end

endmodule

>>> design/quadrature_odometry_core.sv
// quadrature_odometry_core: differential-drive odometry from two encoders.
// A request is accepted only while idle; edge and zero requests go straight to the
// result state, a tick first steps through the sequencer, and the result waits there
// until taken; a tick makes four passes through the shared 32x32 multiplier.
// Reset: arst_n clears counts, pin history, totals, position, angle, increments, config.
// Depends on qodo_pkg, qodo_apb, qodo_mul, qodo_edge.

module quadrature_odometry_core import qodo_pkg::*; #(
	parameter int COUNT_WIDTH   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic               pin_clk,
	input  logic               pin_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] left_total,
	output logic signed [31:0] right_total,
	output logic signed [47:0] distance,
	output logic signed [47:0] heading,
	output logic signed [31:0] fwd_step,
	output logic signed [31:0] turn_step
);

	localparam int          FwdShift = 25 - FRACTION_BITS;
	localparam int          RotShift = 48 - FRACTION_BITS;
	localparam logic [31:0] IncCap   = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_LEFT  = 2'd0,
		OP_RIGHT = 2'd1,
		OP_TICK  = 2'd2,
		OP_ZERO  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_L, S_MUL_R, S_SUM, S_DIFF, S_DLO, S_DHI, S_ACC, S_ROT, S_ANG, S_DONE
	} state_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} sm_t;

	// Sign-magnitude add, zero is always positive
	function automatic sm_t sm_add(input logic an, input logic [63:0] am,
			input logic bn, input logic [63:0] bm);
		sm_t r;
		if (an == bn) begin
			r.neg = an;
			r.mag = am + bm;
		end else if (am >= bm) begin
			r.neg = an;
			r.mag = am - bm;
		end else begin
			r.neg = bn;
			r.mag = bm - am;
		end
		if (r.mag == '0) r.neg = 1'b0;
		return r;
	endfunction

	// Clamp a magnitude to the increment range and apply the sign
	function automatic logic [31:0] to_inc(input logic neg, input logic [95:0] mag);
		logic [31:0] m;
		m = (mag > 96'(IncCap)) ? IncCap : mag[31:0];
		return neg ? -m : m;
	endfunction

	cfg_t                          cfg;
	op_t                           op;
	state_t                        state_q;
	logic                          accept, load_out;
	logic signed [COUNT_WIDTH-1:0] left_count, right_count;

	logic [WORD_W-1:0]   mul_a, mul_b;
	logic [2*WORD_W-1:0] prod_q;

	// Odometry state
	logic [31:0]        left_sum_q, right_sum_q;
	logic [47:0]        position_q, angle_q;
	logic signed [31:0] fwd_inc_q, rot_inc_q;

	// Tick intermediates
	logic [31:0] lmag_q, rmag_q;
	logic        lneg_q, rneg_q;
	logic [63:0] lm_q, rm_q, plo_q;
	sm_t         sum_q, diff_q;
	logic [95:0] acc_q;

	// Result register
	logic               out_valid_q;
	logic signed [31:0] left_total_q, right_total_q, fwd_step_q, turn_step_q;
	logic signed [47:0] distance_q, heading_q;

	assign op        = op_t'(operation);
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign left_total  = left_total_q;
	assign right_total = right_total_q;
	assign distance    = distance_q;
	assign heading     = heading_q;
	assign fwd_step    = fwd_step_q;
	assign turn_step   = turn_step_q;

	qodo_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qodo_edge #(.CW(COUNT_WIDTH)) u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept && op == OP_LEFT),
		.clear   (accept && (op == OP_TICK || op == OP_ZERO)),
		.pin_clk (pin_clk),
		.pin_b   (pin_b),
		.reverse (cfg.left_reverse),
		.count   (left_count)
	);

	qodo_edge #(.CW(COUNT_WIDTH)) u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept && op == OP_RIGHT),
		.clear   (accept && (op == OP_TICK || op == OP_ZERO)),
		.pin_clk (pin_clk),
		.pin_b   (pin_b),
		.reverse (cfg.right_reverse),
		.count   (right_count)
	);

	// Multiplier operand select per sequencer step
	always_comb begin
		case (state_q)
			S_MUL_L: begin
				mul_a = lmag_q;
				mul_b = cfg.left_gain;
			end
			S_MUL_R: begin
				mul_a = rmag_q;
				mul_b = cfg.right_gain;
			end
			S_DLO: begin
				mul_a = diff_q.mag[31:0];
				mul_b = cfg.deg_gain;
			end
			S_DHI: begin
				mul_a = diff_q.mag[63:32];
				mul_b = cfg.deg_gain;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	qodo_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			left_total_q  <= '0;
			right_total_q <= '0;
			distance_q    <= '0;
			heading_q     <= '0;
			fwd_step_q    <= '0;
			turn_step_q   <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= (op == OP_TICK) ? S_MUL_L : S_DONE;
				end
				S_MUL_L: state_q <= S_MUL_R;
				S_MUL_R: state_q <= S_SUM;
				S_SUM:   state_q <= S_DIFF;
				S_DIFF:  state_q <= S_DLO;
				S_DLO:   state_q <= S_DHI;
				S_DHI:   state_q <= S_ACC;
				S_ACC:   state_q <= S_ROT;
				S_ROT:   state_q <= S_ANG;
				S_ANG:   state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q       <= S_IDLE;
						left_total_q  <= left_sum_q;
						right_total_q <= right_sum_q;
						distance_q    <= position_q;
						heading_q     <= angle_q;
						fwd_step_q    <= fwd_inc_q;
						turn_step_q   <= rot_inc_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Totals, position, angle and increments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sum_q  <= '0;
			right_sum_q <= '0;
			position_q  <= '0;
			angle_q     <= '0;
			fwd_inc_q   <= '0;
			rot_inc_q   <= '0;
		end else begin
			if (accept && op == OP_TICK) begin
				left_sum_q  <= left_sum_q + 32'(left_count);
				right_sum_q <= right_sum_q + 32'(right_count);
			end else if (accept && op == OP_ZERO) begin
				left_sum_q  <= '0;
				right_sum_q <= '0;
				position_q  <= '0;
				angle_q     <= '0;
			end
			if (state_q == S_DIFF) fwd_inc_q <= to_inc(sum_q.neg, 96'(sum_q.mag >> FwdShift));
			if (state_q == S_DLO) position_q <= position_q + 48'(fwd_inc_q);
			if (state_q == S_ROT) rot_inc_q <= to_inc(diff_q.neg, acc_q >> RotShift);
			if (state_q == S_ANG) angle_q <= angle_q + 48'(rot_inc_q);
		end
	end

	// Tick working registers
	always_ff @(posedge clk) begin
		if (accept && op == OP_TICK) begin
			lneg_q <= left_count[COUNT_WIDTH-1];
			rneg_q <= right_count[COUNT_WIDTH-1];
			lmag_q <= 32'(left_count[COUNT_WIDTH-1] ? -left_count : left_count);
			rmag_q <= 32'(right_count[COUNT_WIDTH-1] ? -right_count : right_count);
		end
		case (state_q)
			S_MUL_R: lm_q <= prod_q;
			S_SUM: begin
				rm_q  <= prod_q;
				sum_q <= sm_add(rneg_q && (prod_q != '0), prod_q,
						lneg_q && (lm_q != '0), lm_q);
			end
			S_DIFF: begin
				diff_q <= sm_add(rneg_q && (rm_q != '0), rm_q,
						!lneg_q && (lm_q != '0), lm_q);
			end
			S_DHI:   plo_q <= prod_q;
			S_ACC:   acc_q <= {prod_q, 32'b0} + {32'b0, plo_q};
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// A tick hands both counts over and clears them
	a_tick_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_TICK |=> left_count == '0 && right_count == '0)
		else $error("counts not cleared by tick");

	// Zero clears totals and odometry accumulators
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_ZERO |=> left_sum_q == '0 && right_sum_q == '0 &&
			position_q == '0 && angle_q == '0)
		else $error("zero request left state behind");

	// Increments saturate symmetrically, never at the most negative code
	a_inc_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_inc_q != 32'sh8000_0000 && rot_inc_q != 32'sh8000_0000)
		else $error("increment reached most negative value");
`endif

endmodule
